[sv/uets_pkg.sv]
// shared types and constants for the usb endpoint transfer sequencer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package uets_pkg;

    typedef enum logic [2:0] {
        REQ_BUS_RESET   = 3'd0,
        REQ_OPEN        = 3'd1,
        REQ_START       = 3'd2,
        REQ_DONE_OK     = 3'd3,
        REQ_DONE_ERR    = 3'd4,
        REQ_STALL       = 3'd5,
        REQ_CLEAR_STALL = 3'd6,
        REQ_SETUP       = 3'd7
    } t_req_type;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    localparam logic [1:0] ARM_NONE  = 2'd0;
    localparam logic [1:0] ARM_DATA  = 2'd1;
    localparam logic [1:0] ARM_STALL = 2'd2;

    localparam logic [1:0] EP_KIND_CONTROL = 2'd0;
    localparam logic [1:0] EP_KIND_ISO     = 2'd1;

    localparam logic [6:0] SETUP_LEN = 7'd8;
    localparam logic [6:0] CRC_LEN   = 7'd2;

    // one endpoint direction as kept in the table
    typedef struct packed {
        logic [6:0]  mps;
        logic [15:0] length;
        logic        zld;
        logic [15:0] pos;
        logic [6:0]  last_pkt;
        logic        busy;
        logic [1:0]  kind;
        logic        halted;
    } t_ep_dir;

    // one table row: index 0 is OUT, index 1 is IN
    typedef t_ep_dir [1:0] t_ep_row;

    typedef struct packed {
        t_req_type   req_type;
        logic [3:0]  ep_num;
        logic        dir_in;
        logic [1:0]  ep_kind;
        logic [6:0]  max_packet;
        logic [15:0] byte_count;
        logic [6:0]  rx_len;
    } t_req;

    typedef struct packed {
        logic [1:0]  arm_kind;
        logic [6:0]  arm_len;
        logic [15:0] data_offset;
        logic [11:0] mem_ptr;
        logic        alloc_overflow;
        logic        xfer_complete;
        logic [15:0] complete_bytes;
        logic        setup_accepted;
        logic        ep_halted;
    } t_result;

    typedef struct packed {
        logic we;
        logic clr_all;
    } t_wb;

endpackage

`default_nettype wire

[sv/uets_ep_ram.sv]
// endpoint table memory: one row per endpoint, both directions side by side
// synchronous registered read, row valid bits make unwritten rows read as zero
// depends on uets_pkg
`timescale 1ns / 1ps
`default_nettype none

module uets_ep_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_re,
    input  wire [AW-1:0]         i_raddr,
    output uets_pkg::t_ep_row    o_rdata,
    input  wire                  i_we,
    input  wire                  i_clr_all,
    input  wire [AW-1:0]         i_waddr,
    input  uets_pkg::t_ep_row    i_wdata
);
    import uets_pkg::*;

    t_ep_row            mem [DEPTH];
    t_ep_row            r_rd;
    logic               r_rd_valid;
    logic [DEPTH-1:0]   r_valid;
    logic [DEPTH-1:0]   n_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd <= mem[i_raddr];
        end
    end

    always_comb begin
        n_valid = i_clr_all ? '0 : r_valid;
        if (i_we) begin
            n_valid[i_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rd : '0;

endmodule

`default_nettype wire

[sv/uets_ep_alu.sv]
// event logic: takes the fetched row and global state, returns the row to write back,
// the new global state and the result beat; purely combinational
// depends on uets_pkg
`timescale 1ns / 1ps
`default_nettype none

module uets_ep_alu #(
    parameter int NUM_EP        = 16,
    parameter int MAX_PKT       = 64,
    parameter int PKT_MEM_BYTES = 4096,
    localparam int FP_W         = $clog2(PKT_MEM_BYTES + 1),
    localparam int FS_W         = FP_W + 1
) (
    input  uets_pkg::t_req      i_req,
    input  uets_pkg::t_ep_row   i_row,
    input  wire                 i_stall,
    input  wire [FP_W-1:0]      i_in_free,
    input  wire [FP_W-1:0]      i_out_free,
    output uets_pkg::t_ep_row   o_row,
    output uets_pkg::t_wb       o_wb,
    output logic                o_stall,
    output logic [FP_W-1:0]     o_in_free,
    output logic [FP_W-1:0]     o_out_free,
    output uets_pkg::t_result   o_res
);
    import uets_pkg::*;

    typedef struct packed {
        t_ep_dir     d;
        logic        fin;
        logic [1:0]  arm_kind;
        logic [6:0]  arm_len;
        logic [15:0] off;
    } t_step;

    // next IN packet; fin when nothing is left to send
    function automatic t_step f_in_next(t_ep_dir d);
        t_step       s;
        logic [15:0] rem;
        logic [15:0] pkt;
        s   = '0;
        s.d = d;
        rem = d.length - d.pos;
        pkt = (rem > {9'd0, d.mps}) ? {9'd0, d.mps} : rem;
        if (!d.zld && d.length != 16'd0 && d.pos < d.length) begin
            s.arm_kind   = ARM_DATA;
            s.arm_len    = pkt[6:0];
            s.off        = d.pos;
            s.d.pos      = d.pos + pkt;
            s.d.last_pkt = pkt[6:0];
        end else if (!d.zld && d.length == 16'd0) begin
            s.arm_kind   = ARM_DATA;
            s.d.zld      = 1'b1;
            s.d.last_pkt = 7'd0;
            s.fin        = 1'b1;
        end else begin
            s.fin = 1'b1;
        end
        return s;
    endfunction

    // account an OUT packet of n bytes; fin on short or final packet
    function automatic t_step f_out_next(t_ep_dir d, logic [6:0] n);
        t_step       s;
        logic [15:0] rem;
        logic [15:0] take;
        logic [15:0] npos;
        s    = '0;
        s.d  = d;
        rem  = d.length - d.pos;
        take = ({9'd0, n} > rem) ? rem : {9'd0, n};
        npos = d.pos + take;
        if (!d.zld && d.length != 16'd0 && d.pos < d.length) begin
            s.off   = d.pos;
            s.d.pos = npos;
            if (n != d.mps || npos == d.length) begin
                s.fin = 1'b1;
            end else begin
                s.arm_kind = ARM_DATA;
                s.arm_len  = d.mps;
            end
        end else if (!d.zld && d.length == 16'd0) begin
            s.arm_kind = ARM_DATA;
            s.arm_len  = d.mps;
            s.d.zld    = 1'b1;
            s.fin      = 1'b1;
        end else begin
            s.fin = 1'b1;
        end
        return s;
    endfunction

    logic            ep0;
    logic            in_range;
    logic [6:0]      mps_sat;
    logic [FS_W-1:0] in_sum;
    logic [FS_W-1:0] out_sum;
    logic [FS_W-1:0] out_sum_ctl;
    logic            in_ovf;
    logic            out_ovf;
    logic            out_ovf_ctl;
    logic [6:0]      rx_bytes;
    t_ep_dir         d;
    t_step           step;
    logic            fin;

    assign ep0         = (i_req.ep_num == 4'd0);
    assign in_range    = ({1'b0, i_req.ep_num} < 5'(NUM_EP));
    assign mps_sat     = (i_req.max_packet > 7'(MAX_PKT)) ? 7'(MAX_PKT) : i_req.max_packet;
    assign in_sum      = {1'b0, i_in_free} + FS_W'(mps_sat);
    assign out_sum     = {1'b0, i_out_free} + FS_W'(mps_sat);
    assign out_sum_ctl = out_sum + FS_W'(SETUP_LEN);
    assign in_ovf      = in_sum > FS_W'(PKT_MEM_BYTES);
    assign out_ovf     = out_sum > FS_W'(PKT_MEM_BYTES);
    assign out_ovf_ctl = out_sum_ctl > FS_W'(PKT_MEM_BYTES);
    // crc bytes are not data; anything shorter counts as empty
    assign rx_bytes    = (i_req.rx_len >= CRC_LEN) ? i_req.rx_len - CRC_LEN : 7'd0;

    always_comb begin
        o_row      = i_row;
        d          = i_row[i_req.dir_in];
        o_stall    = i_stall;
        o_in_free  = i_in_free;
        o_out_free = i_out_free;
        o_res      = '0;
        o_wb       = '0;
        step       = '0;
        fin        = 1'b0;
        unique case (i_req.req_type) inside
            REQ_BUS_RESET: begin
                o_row           = '0;
                o_row[0].mps    = 7'(MAX_PKT);
                o_row[1].mps    = 7'(MAX_PKT);
                o_in_free       = FP_W'(MAX_PKT);
                o_out_free      = FP_W'(MAX_PKT) + FP_W'(SETUP_LEN);
                o_stall         = 1'b0;
                o_wb.we         = 1'b1;
                o_wb.clr_all    = 1'b1;
                o_res.arm_kind  = ARM_DATA;
                o_res.arm_len   = SETUP_LEN;
            end
            REQ_SETUP: begin
                if (!i_row[0].busy && !i_row[1].busy) begin
                    o_stall              = 1'b0;
                    o_res.arm_kind       = ARM_DATA;
                    o_res.arm_len        = SETUP_LEN;
                    o_res.setup_accepted = 1'b1;
                end
                o_res.ep_halted = o_stall;
            end
            default: begin
                if (in_range) begin
                    o_wb.we = 1'b1;
                    unique case (i_req.req_type) inside
                        REQ_OPEN: begin
                            d.mps = mps_sat;
                            if (i_req.ep_kind == EP_KIND_CONTROL) begin
                                o_res.mem_ptr = 12'(i_in_free);
                                if (in_ovf || out_ovf_ctl) begin
                                    o_res.alloc_overflow = 1'b1;
                                end else begin
                                    o_in_free  = in_sum[FP_W-1:0];
                                    o_out_free = out_sum_ctl[FP_W-1:0];
                                end
                                d.kind                       = EP_KIND_CONTROL;
                                o_row[!i_req.dir_in].mps     = mps_sat;
                                o_row[!i_req.dir_in].kind    = EP_KIND_CONTROL;
                                o_res.arm_kind               = ARM_DATA;
                                o_res.arm_len                = SETUP_LEN;
                            end else begin
                                d.kind = i_req.ep_kind;
                                if (i_req.dir_in) begin
                                    o_res.mem_ptr = 12'(i_in_free);
                                    if (in_ovf) o_res.alloc_overflow = 1'b1;
                                    else o_in_free = in_sum[FP_W-1:0];
                                end else begin
                                    o_res.mem_ptr = 12'(i_out_free);
                                    if (out_ovf) o_res.alloc_overflow = 1'b1;
                                    else o_out_free = out_sum[FP_W-1:0];
                                end
                            end
                        end
                        REQ_START: begin
                            d.length = i_req.byte_count;
                            d.pos    = 16'd0;
                            d.zld    = 1'b0;
                            d.busy   = 1'b1;
                            if (i_req.dir_in) begin
                                step              = f_in_next(d);
                                d                 = step.d;
                                o_res.arm_kind    = step.arm_kind;
                                o_res.arm_len     = step.arm_len;
                                o_res.data_offset = step.off;
                            end else begin
                                o_res.arm_kind = ARM_DATA;
                                o_res.arm_len  = d.mps;
                            end
                        end
                        REQ_DONE_OK, REQ_DONE_ERR: begin
                            if (!d.busy) begin
                                fin = 1'b0;
                            end else if (ep0 && i_stall) begin
                                o_res.arm_kind = ARM_STALL;
                            end else if (i_req.req_type == REQ_DONE_ERR) begin
                                // re-arm the packet that failed
                                o_res.arm_kind = ARM_DATA;
                                if (i_req.dir_in) begin
                                    o_res.arm_len = d.last_pkt;
                                    o_res.data_offset = (d.pos >= {9'd0, d.last_pkt}) ?
                                        d.pos - {9'd0, d.last_pkt} : 16'd0;
                                end else begin
                                    o_res.arm_len     = d.mps;
                                    o_res.data_offset = d.pos;
                                end
                            end else begin
                                if (i_req.dir_in) step = f_in_next(d);
                                else step = f_out_next(d, rx_bytes);
                                d                 = step.d;
                                fin               = step.fin;
                                o_res.arm_kind    = step.arm_kind;
                                o_res.arm_len     = step.arm_len;
                                o_res.data_offset = step.off;
                            end
                            if (fin) begin
                                o_res.xfer_complete  = 1'b1;
                                o_res.complete_bytes = d.pos;
                                d.busy               = 1'b0;
                            end
                        end
                        REQ_STALL: begin
                            if (ep0) begin
                                o_stall        = 1'b1;
                                o_res.arm_kind = ARM_STALL;
                            end else if (d.kind != EP_KIND_ISO) begin
                                d.halted = 1'b1;
                            end
                        end
                        REQ_CLEAR_STALL: begin
                            if (ep0) o_stall = 1'b0;
                            else if (d.kind != EP_KIND_ISO) d.halted = 1'b0;
                        end
                        default: begin
                            o_wb.we = 1'b0;
                        end
                    endcase
                    o_row[i_req.dir_in] = d;
                    o_res.ep_halted     = ep0 ? o_stall : d.halted;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/usb_endpoint_transfer_sequencer.sv]
// usb device endpoint transfer sequencer, top level
// flow: an accepted event is registered and its table row is read, the exec state does the
// read-modify-write on the same row, then the result beat appears on o_strobe; no new event
// is taken until the state is back in idle; busy is high during the write cycle
// reset: synchronous active low; table rows read as zero through row valid bits, no sweep
// results cannot be held off; each beat stands for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module usb_endpoint_transfer_sequencer #(
    parameter int NUM_EP        = 16,
    parameter int MAX_PKT       = 64,
    parameter int PKT_MEM_BYTES = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire [2:0]   i_req_type,
    input  wire [3:0]   i_ep_num,
    input  wire         i_dir_in,
    input  wire [1:0]   i_ep_kind,
    input  wire [6:0]   i_max_packet,
    input  wire [15:0]  i_byte_count,
    input  wire [6:0]   i_rx_len,
    output logic        o_strobe,
    output logic [1:0]  o_arm_kind,
    output logic [6:0]  o_arm_len,
    output logic [15:0] o_data_offset,
    output logic [11:0] o_mem_ptr,
    output logic        o_alloc_overflow,
    output logic        o_xfer_complete,
    output logic [15:0] o_complete_bytes,
    output logic        o_setup_accepted,
    output logic        o_ep_halted
);
    import uets_pkg::*;

    localparam int FP_W = $clog2(PKT_MEM_BYTES + 1);
    localparam int EP_AW = (NUM_EP > 1) ? $clog2(NUM_EP) : 1;

    t_state             r_state;
    t_state             n_state;
    t_req               r_req;
    logic               r_stall;
    logic [FP_W-1:0]    r_in_free;
    logic [FP_W-1:0]    r_out_free;
    logic               r_strobe;
    t_result            r_res;

    logic               accept;
    logic               ram_we;
    logic [EP_AW-1:0]   raddr;
    logic [EP_AW-1:0]   waddr;
    t_ep_row            rd_row;
    t_ep_row            wr_row;
    t_wb                wb;
    logic               alu_stall;
    logic [FP_W-1:0]    alu_in_free;
    logic [FP_W-1:0]    alu_out_free;
    t_result            alu_res;

    // setup always looks at endpoint 0
    assign raddr = (t_req_type'(i_req_type) == REQ_SETUP) ? '0 : i_ep_num[EP_AW-1:0];
    assign waddr = (r_req.req_type == REQ_BUS_RESET) ? '0 : r_req.ep_num[EP_AW-1:0];

    uets_ep_ram #(
        .DEPTH (NUM_EP),
        .AW    (EP_AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (accept),
        .i_raddr   (raddr),
        .o_rdata   (rd_row),
        .i_we      (ram_we),
        .i_clr_all (ram_we && wb.clr_all),
        .i_waddr   (waddr),
        .i_wdata   (wr_row)
    );

    uets_ep_alu #(
        .NUM_EP        (NUM_EP),
        .MAX_PKT       (MAX_PKT),
        .PKT_MEM_BYTES (PKT_MEM_BYTES)
    ) u_alu (
        .i_req      (r_req),
        .i_row      (rd_row),
        .i_stall    (r_stall),
        .i_in_free  (r_in_free),
        .i_out_free (r_out_free),
        .o_row      (wr_row),
        .o_wb       (wb),
        .o_stall    (alu_stall),
        .o_in_free  (alu_in_free),
        .o_out_free (alu_out_free),
        .o_res      (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        accept  = 1'b0;
        ram_we  = 1'b0;
        busy    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                accept = start;
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                busy    = 1'b1;
                ram_we  = wb.we;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall    <= 1'b0;
            r_in_free  <= '0;
            r_out_free <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_EXEC);
            if (r_state == S_EXEC) begin
                r_stall    <= alu_stall;
                r_in_free  <= alu_in_free;
                r_out_free <= alu_out_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.req_type   <= t_req_type'(i_req_type);
            r_req.ep_num     <= i_ep_num;
            r_req.dir_in     <= i_dir_in;
            r_req.ep_kind    <= i_ep_kind;
            r_req.max_packet <= i_max_packet;
            r_req.byte_count <= i_byte_count;
            r_req.rx_len     <= i_rx_len;
        end
        if (r_state == S_EXEC) begin
            r_res <= alu_res;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_arm_kind       = r_res.arm_kind;
    assign o_arm_len        = r_res.arm_len;
    assign o_data_offset    = r_res.data_offset;
    assign o_mem_ptr        = r_res.mem_ptr;
    assign o_alloc_overflow = r_res.alloc_overflow;
    assign o_xfer_complete  = r_res.xfer_complete;
    assign o_complete_bytes = r_res.complete_bytes;
    assign o_setup_accepted = r_res.setup_accepted;
    assign o_ep_halted      = r_res.ep_halted;

endmodule

`default_nettype wire
